[rtl/core/wsg_pkg.sv]
package wsg_pkg;

	typedef enum logic [1:0] {
		MODE_SINE   = 2'd0,
		MODE_SQUARE = 2'd1,
		MODE_SAW    = 2'd2,
		MODE_AM     = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_MODE      = 3'd0,
		REG_LENGTH    = 3'd1,
		REG_TONE      = 3'd2,
		REG_CARRIER   = 3'd3,
		REG_OFFSET    = 3'd4,
		REG_HIGH      = 3'd5,
		REG_LOW       = 3'd6
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEG,
		ST_DIV,
		ST_SIN_X2,
		ST_SIN_POLY,
		ST_SIN_R,
		ST_AM_MUL,
		ST_OUT
	} state_t;

	localparam logic [31:0] K1 = 32'd1686629713;
	localparam logic [31:0] K3 = 32'd693598668;
	localparam logic [31:0] K5 = 32'd85569306;
	localparam logic [31:0] K7 = 32'd5026995;
	localparam logic [31:0] K9 = 32'd172272;

	function automatic logic [31:0] poly_k(input logic [2:0] i);
		case (i)
			3'd0: poly_k = K7;
			3'd1: poly_k = K5;
			3'd2: poly_k = K3;
			3'd3: poly_k = K1;
			default: poly_k = K9;
		endcase
	endfunction

endpackage

[rtl/core/waveform_sample_generator.sv]
// Waveform sample generator.
// Input channel: restart with valid/ready; each accepted beat yields one
// output beat carrying sample (signed Q1.(SAMPLE_BITS-1)) and last.
// Registers are written through cfg_we/cfg_idx/cfg_data; the user must write
// them only while idle, which the block does not enforce. Each beat is
// computed by a small sequencer around one shared multiplier (Taylor sine,
// Horner steps, envelope product) and a restoring divider for the sawtooth
// ramp, one quotient bit per cycle. A modulated tone runs the sine steps
// twice (envelope tone, then carrier); square and zero runs go straight to
// the output beat. The next input beat is taken in the cycle after the
// output beat is taken, so the block takes no new beat before it is through
// with the current one.
// in_ready is low from acceptance until the output beat is taken; one beat
// is in flight at a time. A stalled receiver holds out_valid and payload.
// Reset clears registers to their defaults (length 1) and the run state.
// The index wraps after buffer_length samples; restart forces index zero.
module waveform_sample_generator #(
	parameter int SAMPLE_BITS = 16,
	parameter int PHASE_BITS  = 32,
	parameter int COUNT_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_idx,
	input  logic [31:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          restart,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          last
);

	localparam int DW = SAMPLE_BITS + COUNT_BITS;
	localparam int SHR_P = (PHASE_BITS > 32) ? PHASE_BITS - 32 : 0;
	localparam int SHL_P = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
	localparam logic [COUNT_BITS-1:0] CMAX = '1;
	localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

	wsg_pkg::state_t state_q, state_d;

	logic [1:0]  mode_q;
	logic [15:0] len_q, offset_q, hi_dur_q, lo_dur_q;
	logic [31:0] tstep_q, cstep_q;

	logic [15:0]           idx_q;
	logic [COUNT_BITS-1:0] seg_q;
	logic                  low_q;
	logic [PHASE_BITS-1:0] tph_q, cph_q;

	logic [COUNT_BITS-1:0] hi_c, lo_c;
	always_comb begin
		hi_c = (COUNT_BITS < 16 && {16'd0, hi_dur_q} > 32'(CMAX)) ? CMAX : COUNT_BITS'(hi_dur_q);
		lo_c = (COUNT_BITS < 16 && {16'd0, lo_dur_q} > 32'(CMAX)) ? CMAX : COUNT_BITS'(lo_dur_q);
	end

	function automatic logic [31:0] turns(input logic [PHASE_BITS-1:0] p);
		logic [PHASE_BITS+31:0] w;
		w = {32'd0, p} >> SHR_P;
		w = w << SHL_P;
		turns = w[31:0];
	endfunction

	// seg decision (up to three skips, combinational on narrow values)
	logic [COUNT_BITS-1:0] segn;
	logic                  lown;
	always_comb begin
		segn = seg_q;
		lown = low_q;
		for (int k = 0; k < 3; k++) begin
			if (!lown && segn >= hi_c) begin
				lown = 1'b1;
				segn = '0;
			end else if (lown && segn >= lo_c) begin
				lown = 1'b0;
				segn = '0;
			end
		end
	end

	// shared multiplier
	logic [31:0] ma_q, mb_q;
	logic [63:0] mp;
	assign mp = ma_q * mb_q;

	logic [31:0] t_q;
	logic [1:0]  quad_q;
	logic [31:0] x30_q, x2_q;
	logic [2:0]  k_q;
	logic        sec_q;
	logic signed [SAMPLE_BITS-1:0] env_s_q, res_q;
	logic [DW-1:0] rem_q, quo_q;
	logic [7:0]    cnt_q;
	logic          run_seg_q;
	logic          last_q;

	logic [SAMPLE_BITS-1:0] sv;
	logic [32:0] rnd;
	always_comb begin
		rnd = {1'b0, mp[61:30]} + (33'd1 << (30 - SAMPLE_BITS));
		rnd = rnd >> (31 - SAMPLE_BITS);
		sv = (rnd > 33'(SMAX)) ? SMAX : SAMPLE_BITS'(rnd);
	end

	logic [DW:0] dtrial;
	assign dtrial = {rem_q, quo_q[DW-1]} - {{(SAMPLE_BITS+1){1'b0}}, hi_c};

	always_comb begin
		state_d = state_q;
		case (state_q)
			wsg_pkg::ST_IDLE: if (in_valid) state_d = wsg_pkg::ST_SEG;
			wsg_pkg::ST_SEG: begin
				case (wsg_pkg::mode_t'(mode_q))
					wsg_pkg::MODE_SINE, wsg_pkg::MODE_AM: state_d = wsg_pkg::ST_SIN_X2;
					wsg_pkg::MODE_SAW:
						state_d = (run_seg_q && !lown) ? wsg_pkg::ST_DIV : wsg_pkg::ST_OUT;
					default: state_d = wsg_pkg::ST_OUT;
				endcase
			end
			wsg_pkg::ST_DIV: if (cnt_q == 8'(DW - 1)) state_d = wsg_pkg::ST_OUT;
			wsg_pkg::ST_SIN_X2: state_d = wsg_pkg::ST_SIN_POLY;
			wsg_pkg::ST_SIN_POLY: if (k_q == 3'd3) state_d = wsg_pkg::ST_SIN_R;
			wsg_pkg::ST_SIN_R: begin
				if (mode_q == wsg_pkg::MODE_AM && !sec_q) state_d = wsg_pkg::ST_SIN_X2;
				else if (mode_q == wsg_pkg::MODE_AM) state_d = wsg_pkg::ST_AM_MUL;
				else state_d = wsg_pkg::ST_OUT;
			end
			wsg_pkg::ST_AM_MUL: state_d = wsg_pkg::ST_OUT;
			wsg_pkg::ST_OUT: if (out_ready) state_d = wsg_pkg::ST_IDLE;
			default: state_d = wsg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == wsg_pkg::ST_IDLE);
		out_valid = (state_q == wsg_pkg::ST_OUT);
		sample    = res_q;
		last      = last_q;
	end

	// quadrant setup from a turn word
	logic [16:0] xs;
	logic [31:0] tsel;
	always_comb begin
		tsel = t_q;
		xs = tsel[30] ? (17'd65536 - {1'b0, tsel[29:14]}) : {1'b0, tsel[29:14]};
	end

	logic [15:0] len_e;
	assign len_e = (len_q == 16'd0) ? 16'd1 : len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= wsg_pkg::ST_IDLE;
			mode_q   <= 2'd0;
			len_q    <= 16'd1;
			tstep_q  <= '0;
			cstep_q  <= '0;
			offset_q <= '0;
			hi_dur_q <= '0;
			lo_dur_q <= '0;
			idx_q    <= '0;
			seg_q    <= '0;
			low_q    <= 1'b0;
			tph_q    <= '0;
			cph_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (wsg_pkg::reg_idx_t'(cfg_idx))
					wsg_pkg::REG_MODE:    mode_q   <= cfg_data[1:0];
					wsg_pkg::REG_LENGTH:  len_q    <= cfg_data[15:0];
					wsg_pkg::REG_TONE:    tstep_q  <= cfg_data;
					wsg_pkg::REG_CARRIER: cstep_q  <= cfg_data;
					wsg_pkg::REG_OFFSET:  offset_q <= cfg_data[15:0];
					wsg_pkg::REG_HIGH:    hi_dur_q <= cfg_data[15:0];
					wsg_pkg::REG_LOW:     lo_dur_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (state_q == wsg_pkg::ST_IDLE && in_valid && restart) begin
				idx_q <= '0;
				seg_q <= '0;
				low_q <= 1'b0;
				tph_q <= '0;
				cph_q <= '0;
			end
			if (state_q == wsg_pkg::ST_SEG) begin
				if (run_seg_q) begin
					low_q <= lown;
					seg_q <= segn + 1'b1;
				end
			end
			if (state_q == wsg_pkg::ST_OUT && out_ready) begin
				if (last_q) begin
					idx_q <= '0;
					seg_q <= '0;
					low_q <= 1'b0;
					tph_q <= '0;
					cph_q <= '0;
				end else begin
					idx_q <= idx_q + 16'd1;
					tph_q <= tph_q + PHASE_BITS'(tstep_q);
					cph_q <= cph_q + PHASE_BITS'(cstep_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			wsg_pkg::ST_IDLE: begin
				run_seg_q <= (hi_c != '0) || (lo_c != '0);
				sec_q <= 1'b0;
				last_q <= ({1'b0, (restart ? 16'd0 : idx_q)} + 17'd1) >= {1'b0, len_e};
			end
			wsg_pkg::ST_SEG: begin
				res_q <= (run_seg_q && !lown && mode_q == wsg_pkg::MODE_SQUARE) ? SMAX : '0;
				quo_q <= DW'(segn) << (SAMPLE_BITS - 1);
				rem_q <= '0;
				cnt_q <= '0;
				if (mode_q == wsg_pkg::MODE_AM)
					t_q <= turns(tph_q) - 32'h4000_0000;
				else
					t_q <= turns(tph_q + (PHASE_BITS'(offset_q) << (PHASE_BITS - 16)));
			end
			wsg_pkg::ST_DIV: begin
				cnt_q <= cnt_q + 8'd1;
				if (!dtrial[DW]) begin
					rem_q <= dtrial[DW-1:0];
					quo_q <= {quo_q[DW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[DW-2:0], quo_q[DW-1]};
					quo_q <= {quo_q[DW-2:0], 1'b0};
				end
				if (cnt_q == 8'(DW - 1))
					res_q <= SAMPLE_BITS'(!dtrial[DW] ? {quo_q[DW-2:0], 1'b1}
						: {quo_q[DW-2:0], 1'b0});
			end
			wsg_pkg::ST_SIN_X2: begin
				quad_q <= tsel[31:30];
				x30_q <= {1'b0, xs, 14'd0};
				ma_q <= {1'b0, xs, 14'd0};
				mb_q <= {1'b0, xs, 14'd0};
				k_q <= 3'd7;
			end
			wsg_pkg::ST_SIN_POLY: begin
				if (k_q == 3'd7) begin
					x2_q <= mp[61:30];
					ma_q <= mp[61:30];
					mb_q <= wsg_pkg::K9;
					k_q <= 3'd0;
				end else begin
					ma_q <= (k_q == 3'd3) ? x30_q : x2_q;
					mb_q <= wsg_pkg::poly_k(k_q) - mp[61:30];
					k_q <= k_q + 3'd1;
				end
			end
			wsg_pkg::ST_SIN_R: begin
				if (mode_q == wsg_pkg::MODE_AM && !sec_q) begin
					env_s_q <= quad_q[1] ? -$signed(sv) : $signed(sv);
					sec_q <= 1'b1;
					t_q <= turns(cph_q);
				end else if (mode_q == wsg_pkg::MODE_AM) begin
					quad_q <= quad_q;
					ma_q <= 32'(sv);
					mb_q <= 32'($signed({env_s_q[SAMPLE_BITS-1], env_s_q})
						+ $signed({1'b0, SMAX}) + 1);
				end else begin
					res_q <= quad_q[1] ? -$signed(sv) : $signed(sv);
				end
			end
			wsg_pkg::ST_AM_MUL: begin
				res_q <= quad_q[1]
					? -$signed(SAMPLE_BITS'((mp + (64'd1 << (SAMPLE_BITS - 1))) >> SAMPLE_BITS))
					: $signed(SAMPLE_BITS'((mp + (64'd1 << (SAMPLE_BITS - 1))) >> SAMPLE_BITS));
			end
			default: ;
		endcase
	end

endmodule

[tb/waveform_sample_generator_checker.sv]
`timescale 1ns / 100ps

module waveform_sample_generator_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        restart,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic signed [15:0] sample,
	input  logic        last,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic signed [15:0] sample;
		logic               last;
	} beat_t;

	localparam logic [31:0] C1 = 32'd1686629713;
	localparam logic [31:0] C3 = 32'd693598668;
	localparam logic [31:0] C5 = 32'd85569306;
	localparam logic [31:0] C7 = 32'd5026995;
	localparam logic [31:0] C9 = 32'd172272;

	wsg_pkg::mode_t wave_mode;
	logic [15:0] buf_len, offset_turns, high_len, low_len;
	logic [31:0] tone_inc, carrier_inc;
	logic [15:0] idx, seg_cnt;
	logic        low_run;
	logic [31:0] tone_acc, carrier_acc;
	beat_t       expected_beats[$];

	function automatic logic signed [15:0] sine_of(input logic [31:0] t);
		logic [1:0]  q;
		logic [63:0] f, x, x30, x2, s, r, v;
		q = t[31:30];
		f = {48'd0, t[29:14]};
		x = q[0] ? 64'd65536 - f : f;
		x30 = x << 14;
		x2 = (x30 * x30) >> 30;
		s = {32'd0, C9};
		s = C7 - ((x2 * s) >> 30);
		s = C5 - ((x2 * s) >> 30);
		s = C3 - ((x2 * s) >> 30);
		s = C1 - ((x2 * s) >> 30);
		r = (x30 * s) >> 30;
		v = (r + 64'd16384) >> 15;
		if (v > 64'd32767)
			v = 64'd32767;
		return q[1] ? -$signed(v[15:0]) : $signed(v[15:0]);
	endfunction

	task automatic predict_beat(input logic rs);
		logic signed [31:0] seg_val, smp, s, c, mag, env, p;
		logic [31:0]        lenv;
		beat_t              b;
		seg_val = 0;
		lenv = (buf_len == 0) ? 32'd1 : {16'd0, buf_len};
		if (rs) begin
			idx = 0; seg_cnt = 0; low_run = 0; tone_acc = 0; carrier_acc = 0;
		end
		if (high_len != 0 || low_len != 0) begin
			for (int k = 0; k < 3; k++) begin
				if (!low_run && seg_cnt >= high_len) begin
					low_run = 1; seg_cnt = 0;
				end else if (low_run && seg_cnt >= low_len) begin
					low_run = 0; seg_cnt = 0;
				end else
					break;
			end
			if (!low_run) begin
				if (wave_mode == wsg_pkg::MODE_SQUARE)
					seg_val = 32767;
				else
					seg_val = ({16'd0, seg_cnt} << 15) / {16'd0, high_len};
			end
			seg_cnt = seg_cnt + 16'd1;
		end
		case (wave_mode)
			wsg_pkg::MODE_SINE: smp = sine_of(tone_acc + {offset_turns, 16'd0});
			wsg_pkg::MODE_AM: begin
				s = sine_of(tone_acc - 32'h4000_0000);
				c = sine_of(carrier_acc);
				env = s + 32768;
				mag = c < 0 ? -c : c;
				p = (mag * env + 32768) >>> 16;
				smp = c < 0 ? -p : p;
			end
			default: smp = seg_val;
		endcase
		b.sample = smp[15:0];
		b.last = ({16'd0, idx} + 1) >= lenv;
		if (b.last) begin
			idx = 0; seg_cnt = 0; low_run = 0; tone_acc = 0; carrier_acc = 0;
		end else begin
			idx = idx + 16'd1;
			tone_acc = tone_acc + tone_inc;
			carrier_acc = carrier_acc + carrier_inc;
		end
		expected_beats.push_back(b);
	endtask

	always @(posedge clk or negedge arst_n) begin
		beat_t e;
		if (!arst_n) begin
			wave_mode = wsg_pkg::MODE_SINE; buf_len = 1; tone_inc = 0; carrier_inc = 0;
			offset_turns = 0; high_len = 0; low_len = 0;
			idx = 0; seg_cnt = 0; low_run = 0; tone_acc = 0; carrier_acc = 0;
			fail_count = 0;
			expected_beats.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (wsg_pkg::reg_idx_t'(cfg_idx))
					wsg_pkg::REG_MODE:    wave_mode = wsg_pkg::mode_t'(cfg_data[1:0]);
					wsg_pkg::REG_LENGTH:  buf_len = cfg_data[15:0];
					wsg_pkg::REG_TONE:    tone_inc = cfg_data;
					wsg_pkg::REG_CARRIER: carrier_inc = cfg_data;
					wsg_pkg::REG_OFFSET:  offset_turns = cfg_data[15:0];
					wsg_pkg::REG_HIGH:    high_len = cfg_data[15:0];
					wsg_pkg::REG_LOW:     low_len = cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_beat(restart);
			if (out_valid && out_ready) begin
				if (expected_beats.size() == 0) begin
					$error("unexpected beat: sample %0d last %0b", sample, last);
					fail_count++;
				end else begin
					e = expected_beats.pop_front();
					if (sample !== e.sample) begin
						$error("sample: expected %0d, actual %0d", e.sample, sample);
						fail_count++;
					end
					if (last !== e.last) begin
						$error("last: expected %0b, actual %0b", e.last, last);
						fail_count++;
					end
				end
			end
			pending = expected_beats.size();
		end
	end

endmodule

[tb/waveform_sample_generator_tb.sv]
`timescale 1ns / 100ps

module waveform_sample_generator_tb;

	logic        clk, arst_n, cfg_we, in_valid, in_ready, restart;
	logic        out_valid, out_ready, last;
	logic [2:0]  cfg_idx;
	logic [31:0] cfg_data;
	logic signed [15:0] sample;
	int          fail_count, pending, cycle_count;
	bit          sender_done;

	waveform_sample_generator u_dut (.*);
	waveform_sample_generator_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 1000000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
	endfunction

	// receiver stalls; quiet stretches have none
	initial begin
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (cycle_count % 3000 < 600)
				out_ready <= 1;
			else if (out_ready && $urandom_range(0, 3) == 0)
				out_ready <= 0;
			else if (!out_ready)
				out_ready <= (gap_len() < 2);
		end
	end

	task automatic send_beat(input logic rs, input bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		cfg_we <= 0;
		if (g != 0) begin
			in_valid <= 0;
			restart <= 1'($urandom_range(0, 1));
			repeat (g) @(negedge clk);
		end
		in_valid <= 1;
		restart <= rs;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		restart <= 1'($urandom_range(0, 1));
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(input wsg_pkg::reg_idx_t r, input logic [31:0] v);
		cfg_we <= 1;
		cfg_idx <= r;
		cfg_data <= v;
		@(negedge clk);
	endtask

	task automatic pick_regs(input bit extreme);
		logic [15:0] hl, ll, bl;
		write_reg(wsg_pkg::REG_MODE, $urandom_range(0, 3));
		bl = extreme ? 16'hFFFF
			: (($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 40)));
		write_reg(wsg_pkg::REG_LENGTH, {16'd0, bl});
		write_reg(wsg_pkg::REG_TONE, extreme ? 32'hFFFF_FFFF : $urandom);
		write_reg(wsg_pkg::REG_CARRIER, extreme ? 32'hFFFF_FFFF : $urandom);
		write_reg(wsg_pkg::REG_OFFSET, extreme ? 32'h0000_FFFF : $urandom);
		hl = extreme ? 16'hFFFF
			: (($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(1, 12)));
		ll = extreme ? 16'hFFFF
			: (($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(1, 12)));
		if ($urandom_range(0, 15) == 0) begin
			hl = 16'($urandom);
			ll = 16'($urandom);
		end
		write_reg(wsg_pkg::REG_HIGH, {16'd0, hl});
		write_reg(wsg_pkg::REG_LOW, {16'd0, ll});
	endtask

	initial begin
		cfg_we = 0; cfg_idx = 0; cfg_data = 0; in_valid = 0; restart = 0;
		cycle_count = 0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// reset defaults, then each mode with short runs, zero and long durations
		repeat (2) send_beat(0, 0);
		for (int m = 0; m < 4; m++) begin
			drain();
			write_reg(wsg_pkg::REG_MODE, m);
			write_reg(wsg_pkg::REG_LENGTH, 5);
			write_reg(wsg_pkg::REG_TONE, 32'h1000_0000 << m);
			write_reg(wsg_pkg::REG_CARRIER, 32'h3000_0000);
			write_reg(wsg_pkg::REG_OFFSET, 32'h0000_4000);
			write_reg(wsg_pkg::REG_HIGH, (m == 3) ? 0 : 2);
			write_reg(wsg_pkg::REG_LOW, (m == 0) ? 0 : 1);
			for (int i = 0; i < 5; i++) send_beat(i == 3, 0);
		end
		drain();
		pick_regs(1);
		repeat (3) send_beat(0, 1);
		drain();
		write_reg(wsg_pkg::REG_LENGTH, 0);
		write_reg(wsg_pkg::REG_HIGH, 0);
		write_reg(wsg_pkg::REG_LOW, 0);
		repeat (2) send_beat(0, 1);
		for (int blk = 0; blk < 58; blk++) begin
			drain();
			pick_regs(blk == 29);
			for (int i = 0; i < 30; i++)
				send_beat($urandom_range(0, 19) == 0, (blk % 5) != 0);
		end
		drain();
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
